@@ rtl/pts_pkg.sv @@
// Shared types and result codes for the periodic timer scheduler.
// No dependencies.
package pts_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADDED  = 3'd0,
        KIND_REJECT = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_FIRED  = 3'd3,
        KIND_IDLE   = 3'd4
    } kind_t;

endpackage

@@ rtl/periodic_timer_scheduler.sv @@
// Periodic timer scheduler: a row of task slots with a serial search
// for the earliest due task. Depends on pts_pkg and pts_cell.
//
// Usage: drive op and its operand ports with start high while busy is low.
// Add and cancel give one result, formed in S_EXEC from the registered
// request and registered on the outputs; busy is high for one cycle meanwhile.
// A tick runs rounds: the best candidate ripples
// through the chain of cells, one cell per cycle, then the winner fires.
// Each fired task costs one round; one more round finds nothing
// left, so a tick firing k tasks runs k+1 rounds.
// A fired task is reported at the end of the following round, once it is
// known whether another result follows.
// Each result is shown for one cycle on kind, task_id, finished, last
// with out_valid high; last marks the final result of a request.
// The receiver cannot stall; results are never held.
// Reset clears all slots to free and returns the block to idle.
module periodic_timer_scheduler #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] start_time,
    input  logic [31:0] end_time,
    input  logic [31:0] period,
    input  logic [3:0]  cancel_id,
    input  logic [31:0] now_time,
    output logic        out_valid,
    output logic [2:0]  kind,
    output logic [3:0]  task_id,
    output logic        finished,
    output logic        last
);
    import pts_pkg::*;

    localparam int IDW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW  = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FIRE} state_t;

    state_t               state_reg;
    logic [1:0]           op_reg;
    logic [TIME_BITS-1:0] st_reg, en_reg, pe_reg, now_reg;
    logic [3:0]           cid_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 fired_reg;
    logic                 ov_reg, fin_reg, last_reg;
    logic [2:0]           kind_reg;
    logic [3:0]           id_reg;
    logic [3:0]           hold_id_reg;
    logic                 hold_fin_reg;

    logic [NUM_SLOTS-1:0] used_v, fin_v, load_v, clear_v, fire_v;
    logic                 bv [NUM_SLOTS+1];
    logic [TIME_BITS-1:0] bt [NUM_SLOTS+1];
    logic [IDW-1:0]       bi [NUM_SLOTS+1];
    logic                 shift;
    logic                 free_found;
    logic [IDW-1:0]       free_idx;
    logic                 do_add;

    assign bv[0] = 1'b0;
    assign bt[0] = '0;
    assign bi[0] = '0;
    assign shift = (state_reg == S_SCAN);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_v[i])
            begin
                free_found = 1'b1;
                free_idx   = IDW'(i);
            end
        end
    end

    assign do_add = (state_reg == S_EXEC) && (op_reg == OP_ADD)
                    && (st_reg <= en_reg) && free_found;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            load_v[i]  = do_add && (free_idx == IDW'(i));
            clear_v[i] = (state_reg == S_EXEC) && (op_reg == OP_CANCEL)
                         && ({28'd0, cid_reg} == 32'(i));
            fire_v[i]  = (state_reg == S_FIRE) && bv[NUM_SLOTS]
                         && (bi[NUM_SLOTS] == IDW'(i));
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            pts_cell #(.TIME_BITS(TIME_BITS), .IDW(IDW)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .load(load_v[g]), .load_start(st_reg), .load_period(pe_reg),
                .load_end(en_reg), .clear(clear_v[g]), .fire(fire_v[g]),
                .now_time(now_reg), .shift(shift),
                .best_in_valid(bv[g]), .best_in_time(bt[g]), .best_in_id(bi[g]),
                .my_id(IDW'(g)),
                .best_out_valid(bv[g+1]), .best_out_time(bt[g+1]),
                .best_out_id(bi[g+1]),
                .used(used_v[g]), .fire_fin(fin_v[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (op_reg == OP_TICK)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        fired_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        ov_reg    <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg == CW'(NUM_SLOTS - 1))
                        state_reg <= S_FIRE;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_FIRE:
                begin
                    ov_reg <= fired_reg || !bv[NUM_SLOTS];
                    if (bv[NUM_SLOTS])
                    begin
                        fired_reg <= 1'b1;
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= op;
            st_reg  <= TIME_BITS'(start_time);
            en_reg  <= TIME_BITS'(end_time);
            pe_reg  <= TIME_BITS'(period);
            now_reg <= TIME_BITS'(now_time);
            cid_reg <= cancel_id;
        end
        // A fired task is held here and released at the following round's
        // end once we know whether another result follows.
        fin_reg  <= 1'b0;
        last_reg <= 1'b1;
        id_reg   <= '0;
        kind_reg <= KIND_IDLE;
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    kind_reg <= do_add ? KIND_ADDED : KIND_REJECT;
                    id_reg   <= do_add ? 4'(free_idx) : 4'd0;
                end
                OP_CANCEL:
                begin
                    kind_reg <= KIND_CANCEL;
                    id_reg   <= cid_reg;
                end
                default: kind_reg <= KIND_IDLE;
            endcase
        end
        else if (state_reg == S_FIRE)
        begin
            if (bv[NUM_SLOTS])
            begin
                hold_id_reg  <= 4'(bi[NUM_SLOTS]);
                hold_fin_reg <= fin_v[bi[NUM_SLOTS]];
            end
            if (fired_reg)
            begin
                kind_reg <= KIND_FIRED;
                id_reg   <= hold_id_reg;
                fin_reg  <= hold_fin_reg;
                last_reg <= !bv[NUM_SLOTS];
            end
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign task_id   = id_reg;
    assign finished  = fin_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_fire_only_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRE && bv[NUM_SLOTS]) |-> used_v[bi[NUM_SLOTS]])
        else $error("firing a free slot");
    a_load_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_v))
        else $error("add loaded more than one slot");
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !$past(busy)) |-> !out_valid)
        else $error("result with no request");
`endif
endmodule

@@ rtl/pts_cell.sv @@
// One task slot of the scheduler: holds the task and takes part in the
// serial minimum search. No dependencies.
module pts_cell #(
    parameter int TIME_BITS = 32,
    parameter int IDW = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [TIME_BITS-1:0] load_start,
    input  logic [TIME_BITS-1:0] load_period,
    input  logic [TIME_BITS-1:0] load_end,
    input  logic                 clear,
    input  logic                 fire,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic                 shift,
    input  logic                 best_in_valid,
    input  logic [TIME_BITS-1:0] best_in_time,
    input  logic [IDW-1:0]       best_in_id,
    input  logic [IDW-1:0]       my_id,
    output logic                 best_out_valid,
    output logic [TIME_BITS-1:0] best_out_time,
    output logic [IDW-1:0]       best_out_id,
    output logic                 used,
    output logic                 fire_fin
);
    logic                 used_reg;
    logic [TIME_BITS-1:0] next_run_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [TIME_BITS-1:0] end_reg;
    logic                 bv_reg;
    logic [TIME_BITS-1:0] bt_reg;
    logic [IDW-1:0]       bi_reg;
    logic [TIME_BITS:0]   sum;
    logic                 due;
    logic                 take;

    assign sum = {1'b0, now_time} + {1'b0, period_reg};
    assign fire_fin = (period_reg == '0) || sum[TIME_BITS]
                      || (sum[TIME_BITS-1:0] > end_reg);
    assign due = used_reg && (next_run_reg <= now_time);
    // Cells pass the running best down the chain; ties keep the lower slot
    // because lower slots enter the chain first and strict < is used.
    assign take = due && (!best_in_valid || next_run_reg < best_in_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            bv_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                used_reg <= 1'b1;
            else if (clear || (fire && fire_fin))
                used_reg <= 1'b0;
            if (shift)
                bv_reg <= take || best_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            next_run_reg <= load_start;
            period_reg   <= load_period;
            end_reg      <= load_end;
        end
        else if (fire && !fire_fin)
            next_run_reg <= sum[TIME_BITS-1:0];
        if (shift)
        begin
            bt_reg <= take ? next_run_reg : best_in_time;
            bi_reg <= take ? my_id : best_in_id;
        end
    end

    assign best_out_valid = bv_reg;
    assign best_out_time  = bt_reg;
    assign best_out_id    = bi_reg;
    assign used           = used_reg;
endmodule

@@ dv/testbench.sv @@
// Testbench for periodic_timer_scheduler: directed and random add, cancel and tick requests,
// checked against a scoreboard that predicts every result. Depends on pts_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] task_id;
        logic       finished;
        logic       last;
    } sched_result_t;

    class sched_scoreboard;
        bit            used [16];
        logic [31:0]   next_run [16];
        logic [31:0]   every [16];
        logic [31:0]   stop_at [16];
        sched_result_t pending [$];
        int            errors;

        function void push(logic [2:0] k, logic [3:0] id, logic f);
            sched_result_t r;
            r.kind = k;
            r.task_id = id;
            r.finished = f;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_request(logic [1:0] o, logic [31:0] st, logic [31:0] en,
                                   logic [31:0] pe, logic [3:0] cid, logic [31:0] now);
            int free_slot;
            int best;
            int n;
            logic [32:0] nxt;
            bit fin;
            n = pending.size();
            if (o == OP_ADD) begin
                free_slot = -1;
                if (st <= en)
                    for (int i = 15; i >= 0; i--)
                        if (!used[i]) free_slot = i;
                if (free_slot < 0)
                    push(KIND_REJECT, 4'd0, 1'b0);
                else
                begin
                    used[free_slot] = 1;
                    next_run[free_slot] = st;
                    every[free_slot] = pe;
                    stop_at[free_slot] = en;
                    push(KIND_ADDED, 4'(free_slot), 1'b0);
                end
            end
            else if (o == OP_CANCEL)
            begin
                used[cid] = 0;
                push(KIND_CANCEL, cid, 1'b0);
            end
            else if (o == OP_TICK)
            begin
                for (int round = 0; round < 16; round++)
                begin
                    best = -1;
                    for (int i = 0; i < 16; i++)
                        if (used[i] && next_run[i] <= now &&
                            (best < 0 || next_run[i] < next_run[best]))
                            best = i;
                    if (best < 0) break;
                    nxt = {1'b0, now} + {1'b0, every[best]};
                    fin = (every[best] == 0) || nxt[32] || (nxt[31:0] > stop_at[best]);
                    if (fin) used[best] = 0;
                    else next_run[best] = nxt[31:0];
                    push(KIND_FIRED, 4'(best), fin);
                end
                if (pending.size() == n) push(KIND_IDLE, 4'd0, 1'b0);
            end
            else
                push(KIND_IDLE, 4'd0, 1'b0);
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [2:0] k, logic [3:0] id, logic f, logic l);
            sched_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d id=%0d", k, id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
            begin
                $error("kind expected %0d actual %0d", e.kind, k);
                errors++;
            end
            if (id !== e.task_id)
            begin
                $error("task_id expected %0d actual %0d", e.task_id, id);
                errors++;
            end
            if (f !== e.finished)
            begin
                $error("finished expected %0d actual %0d", e.finished, f);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last expected %0d actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] period;
    logic [3:0]  cancel_id;
    logic [31:0] now_time;
    logic        out_valid;
    logic [2:0]  kind;
    logic [3:0]  task_id;
    logic        finished;
    logic        last;

    sched_scoreboard board;
    int          quiet_cycles = 0;
    logic [31:0] clock_now;

    periodic_timer_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .start_time(start_time), .end_time(end_time), .period(period),
        .cancel_id(cancel_id), .now_time(now_time), .out_valid(out_valid),
        .kind(kind), .task_id(task_id), .finished(finished), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(op, start_time, end_time, period, cancel_id, now_time);
        if (rst_n && out_valid)
            board.check_result(kind, task_id, finished, last);
        if ((rst_n && start && !busy) || out_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    task automatic send(logic [1:0] o, logic [31:0] st, logic [31:0] en,
                        logic [31:0] pe, logic [3:0] cid, logic [31:0] now);
        start <= 1'b1;
        op <= o;
        start_time <= st;
        end_time <= en;
        period <= pe;
        cancel_id <= cid;
        now_time <= now;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] st;
        board = new();
        start = 1'b0;
        op = OP_ADD;
        start_time = '0;
        end_time = '0;
        period = '0;
        cancel_id = '0;
        now_time = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_TICK, 0, 0, 0, 0, 0);
        send(OP_ADD, 5, 4, 1, 0, 0);
        send(OP_ADD, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send(OP_ADD, 10, 100, 10, 0, 0);
        send(OP_ADD, 10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send(OP_ADD, 3, 3, 5, 0, 0);
        send(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 50);
        send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        send(OP_CANCEL, 0, 0, 0, 4'd1, 0);
        send(OP_CANCEL, 0, 0, 0, 4'd15, 0);
        for (int i = 0; i < 17; i++)
            send(OP_ADD, 20 + i, 1000, 7, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        while (board.pending.size() != 0) @(posedge clk);

        clock_now = 0;
        for (int n = 0; n < 200; n++)
        begin
            gap();
            if (n == 100)
                while (board.pending.size() != 0) @(posedge clk);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    st = clock_now + $urandom_range(0, 40);
                    if ($urandom_range(0, 4) == 0)
                        send(OP_ADD, any_word(), any_word(), any_word(), 0, 0);
                    else
                        send(OP_ADD, st, st + $urandom_range(0, 200),
                             $urandom_range(0, 30), 0, 0);
                end
                4, 5: send(OP_CANCEL, 0, 0, 0, 4'($urandom), 0);
                6, 7, 8:
                begin
                    clock_now = clock_now + $urandom_range(0, 30);
                    send(OP_TICK, 0, 0, 0, 0,
                         ($urandom_range(0, 9) == 0) ? any_word() : clock_now);
                end
                default: send(OP_NONE, $urandom, $urandom, $urandom, 4'($urandom), $urandom);
            endcase
        end

        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
